>>> sv/hres_pkg.sv
`default_nettype none

package hres_pkg;

    localparam int LEVEL_W    = 16;
    localparam int TIME_W     = 16;
    localparam int TIMER_W    = TIME_W + 2;
    localparam int ELAPSED_W  = 10;
    localparam int KIND_W     = 3;
    localparam int COLOR_W    = 8;
    localparam int NUM_FOG    = 6;
    localparam int FOG_IDX_W  = 3;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 72;

    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 18;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_SET    = 3'd3,
        KIND_RAMP   = 3'd4,
        KIND_TOGGLE = 3'd5
    } hres_kind_t;

    typedef enum logic [1:0] {
        PH_DAY_HOLD   = 2'd0,
        PH_TO_NIGHT   = 2'd1,
        PH_NIGHT_HOLD = 2'd2,
        PH_TO_DAY     = 2'd3
    } hres_phase_t;

    typedef enum logic [2:0] {
        REG_DAY_HOLD     = 3'd0,
        REG_NIGHT_HOLD   = 3'd1,
        REG_RAMP_LEN     = 3'd2,
        REG_NIGHT_LEVEL  = 3'd3,
        REG_TOGGLE_LEVEL = 3'd4
    } hres_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RAMP,
        ST_DIV,
        ST_MUL_TT,
        ST_MUL_CUBE,
        ST_SMOOTH,
        ST_MUL_DIFF,
        ST_STEP,
        ST_FOG,
        ST_DONE
    } hres_state_t;

    function automatic logic [COLOR_W-1:0] fog_base(input logic [FOG_IDX_W-1:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            3'd0:    c = 8'd153;
            3'd1:    c = 8'd204;
            3'd2:    c = 8'd242;
            3'd3:    c = 8'd140;
            3'd4:    c = 8'd191;
            3'd5:    c = 8'd255;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [TIMER_W-1:0] timer_add(input logic [TIMER_W-1:0] a,
                                                     input logic [ELAPSED_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + (TIMER_W+1)'(b);
        return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/hres_div.sv
`default_nettype none

module hres_div
    import hres_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [LEVEL_W-1:0] dividend,
    input  wire logic [LEVEL_W-1:0] divisor,
    output logic                    done,
    output logic [LEVEL_W-1:0]      quotient
);

    // restoring divider, one quotient bit per cycle; dividend < divisor
    localparam int CNT_W = $clog2(LEVEL_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LEVEL_W-1:0] rem_reg, rem_next;
    logic [LEVEL_W-1:0] quo_reg, quo_next;
    logic [LEVEL_W-1:0] dsr_reg, dsr_next;

    logic [LEVEL_W:0]   rem_shift;
    logic [LEVEL_W:0]   rem_diff;
    logic               fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(LEVEL_W);
            rem_next  = dividend;
            quo_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? rem_diff[LEVEL_W-1:0] : rem_shift[LEVEL_W-1:0];
            quo_next = {quo_reg[LEVEL_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> sv/hres_mul.sv
`default_nettype none

module hres_mul
    import hres_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0]      p
);

    logic [MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> sv/hold_ramp_envelope_sequencer.sv
`default_nettype none

// Hold/ramp level sequencer with smoothstep easing and fog color output.
// One item is taken at a time; s_tready is high only while idle. Every item
// yields one result transfer. A command other than tick goes straight from
// execute to the fog colors; a tick first passes the ramp check, and a tick
// that advances a running ramp then runs the 16-step serial divider that
// forms the ramp fraction and passes through the shared 32x18 multiplier
// (three for the easing curve and ramp step, six for the fog colors).
// s_tready returns together with m_tvalid, so a new item is taken only after
// the last one's result is registered. A finished result waits in the output
// register while the next item is accepted; an item that finishes while that
// register is still full stalls until it drains. Registers are 16 bits at byte
// addresses 0x00..0x10 and may be rewritten only while the block is idle.

module hold_ramp_envelope_sequencer
    import hres_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // elapsed[9:0], target_level[25:10], ramp_time[41:26], zero pad
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  wire logic [KIND_W-1:0]     s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // level[15:0], cycle_phase[17:16], cycle_running[18], ramp_running[19],
    // horizon_red/green/blue[43:20], top_red/green/blue[67:44], zero pad
    output logic [M_DATA_W-1:0]        m_tdata
);

    hres_state_t state_reg, state_next;

    hres_kind_t           kind_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [LEVEL_W-1:0]   target_reg;
    logic [TIME_W-1:0]    rtime_reg;

    logic [TIME_W-1:0]  day_hold_reg, night_hold_reg, ramp_len_reg;
    logic [LEVEL_W-1:0] night_level_reg, toggle_level_reg;

    logic               cycle_on_reg, cycle_on_next;
    hres_phase_t        phase_reg, phase_next;
    logic [TIMER_W-1:0] cycle_timer_reg, cycle_timer_next;
    logic               ramp_on_reg, ramp_on_next;
    logic [TIMER_W-1:0] ramp_timer_reg, ramp_timer_next;
    logic [TIME_W-1:0]  ramp_span_reg, ramp_span_next;
    logic [LEVEL_W-1:0] ramp_from_reg, ramp_from_next;
    logic [LEVEL_W-1:0] ramp_to_reg, ramp_to_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [LEVEL_W-1:0]   t_reg, t_next;
    logic [LEVEL_W:0]     s_reg, s_next;
    logic [FOG_IDX_W-1:0] fog_cnt_reg, fog_cnt_next;
    logic [COLOR_W-1:0]   color_reg [NUM_FOG];
    logic [COLOR_W-1:0]   color_next [NUM_FOG];
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic               div_start, div_done;
    logic [LEVEL_W-1:0] div_quotient;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic               in_xfer, cfg_wr, out_free;
    logic [TIMER_W-1:0] ramp_sum, cycle_sum;
    logic               ramp_reach, cycle_reach;
    logic [TIME_W-1:0]  phase_limit;
    logic               ramp_up;
    logic [LEVEL_W-1:0] ramp_diff;
    logic [LEVEL_W:0]   level_inv;
    logic [MUL_P_W:0]   smooth_sum;
    logic [MUL_P_W-1:0] round_sum;
    logic [LEVEL_W-1:0] step_d;
    logic [FOG_IDX_W-1:0] fog_prev;

    logic               br_go;
    logic [LEVEL_W-1:0] br_target;
    logic [TIME_W-1:0]  br_span;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_hold_reg     <= 16'd1000;
            night_hold_reg   <= 16'd1000;
            ramp_len_reg     <= 16'd200;
            night_level_reg  <= 16'd65535;
            toggle_level_reg <= 16'd52429;
        end else if (cfg_wr) begin
            case (hres_reg_t'(paddr[4:2]))
                REG_DAY_HOLD:     day_hold_reg     <= pwdata[TIME_W-1:0];
                REG_NIGHT_HOLD:   night_hold_reg   <= pwdata[TIME_W-1:0];
                REG_RAMP_LEN:     ramp_len_reg     <= pwdata[TIME_W-1:0];
                REG_NIGHT_LEVEL:  night_level_reg  <= pwdata[LEVEL_W-1:0];
                REG_TOGGLE_LEVEL: toggle_level_reg <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (hres_reg_t'(paddr[4:2]))
            REG_DAY_HOLD:     prdata = APB_DATA_W'(day_hold_reg);
            REG_NIGHT_HOLD:   prdata = APB_DATA_W'(night_hold_reg);
            REG_RAMP_LEN:     prdata = APB_DATA_W'(ramp_len_reg);
            REG_NIGHT_LEVEL:  prdata = APB_DATA_W'(night_level_reg);
            REG_TOGGLE_LEVEL: prdata = APB_DATA_W'(toggle_level_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- shared units ----------------
    hres_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ramp_sum[LEVEL_W-1:0]),
        .divisor  (ramp_span_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    hres_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // ---------------- shared terms ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign ramp_sum   = timer_add(ramp_timer_reg, elapsed_reg);
    assign ramp_reach = (ramp_span_reg == '0) || (ramp_sum >= TIMER_W'(ramp_span_reg));
    assign cycle_sum  = timer_add(cycle_timer_reg, elapsed_reg);

    always_comb begin
        case (phase_reg)
            PH_DAY_HOLD:   phase_limit = day_hold_reg;
            PH_NIGHT_HOLD: phase_limit = night_hold_reg;
            default:       phase_limit = ramp_len_reg;
        endcase
    end

    assign cycle_reach = cycle_sum >= TIMER_W'(phase_limit);
    assign ramp_up     = ramp_to_reg >= ramp_from_reg;
    assign ramp_diff   = ramp_up ? ramp_to_reg - ramp_from_reg : ramp_from_reg - ramp_to_reg;
    assign level_inv   = {1'b1, {LEVEL_W{1'b0}}} - {1'b0, level_reg};
    assign smooth_sum  = {1'b0, mul_p} + (MUL_P_W+1)'(64'h8000_0000);
    assign round_sum   = mul_p + MUL_P_W'(32'h8000);
    assign step_d      = round_sum[2*LEVEL_W-1:LEVEL_W];
    assign fog_prev    = fog_cnt_reg - FOG_IDX_W'(1);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_xfer) state_next = ST_EXEC;
            ST_EXEC:     state_next = (kind_reg == KIND_TICK) ? ST_RAMP : ST_FOG;
            ST_RAMP:     state_next = (ramp_on_reg && !ramp_reach) ? ST_DIV : ST_FOG;
            ST_DIV:      if (div_done) state_next = ST_MUL_TT;
            ST_MUL_TT:   state_next = ST_MUL_CUBE;
            ST_MUL_CUBE: state_next = ST_SMOOTH;
            ST_SMOOTH:   state_next = ST_MUL_DIFF;
            ST_MUL_DIFF: state_next = ST_STEP;
            ST_STEP:     state_next = ST_FOG;
            ST_FOG:      if (fog_cnt_reg == FOG_IDX_W'(NUM_FOG)) state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: datapath and unit control ----------------
    always_comb begin
        cycle_on_next    = cycle_on_reg;
        phase_next       = phase_reg;
        cycle_timer_next = cycle_timer_reg;
        ramp_on_next     = ramp_on_reg;
        ramp_timer_next  = ramp_timer_reg;
        ramp_span_next   = ramp_span_reg;
        ramp_from_next   = ramp_from_reg;
        ramp_to_next     = ramp_to_reg;
        level_next       = level_reg;
        t_next           = t_reg;
        s_next           = s_reg;
        fog_cnt_next     = fog_cnt_reg;
        color_next       = color_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        div_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        br_go            = 1'b0;
        br_target        = '0;
        br_span          = '0;

        case (state_reg)
            ST_IDLE: begin
                fog_cnt_next = '0;
            end
            ST_EXEC: begin
                case (kind_reg)
                    KIND_TICK: begin
                        if (cycle_on_reg) begin
                            if (cycle_reach) begin
                                cycle_timer_next = '0;
                                phase_next       = hres_phase_t'(phase_reg + 2'd1);
                                if (phase_reg == PH_DAY_HOLD) begin
                                    br_go     = 1'b1;
                                    br_target = night_level_reg;
                                    br_span   = ramp_len_reg;
                                end else if (phase_reg == PH_NIGHT_HOLD) begin
                                    br_go     = 1'b1;
                                    br_target = '0;
                                    br_span   = ramp_len_reg;
                                end
                            end else begin
                                cycle_timer_next = cycle_sum;
                            end
                        end
                    end
                    KIND_START: begin
                        cycle_on_next    = 1'b1;
                        phase_next       = PH_DAY_HOLD;
                        cycle_timer_next = '0;
                    end
                    KIND_STOP: begin
                        cycle_on_next    = 1'b0;
                        cycle_timer_next = '0;
                    end
                    KIND_SET: begin
                        level_next      = target_reg;
                        ramp_on_next    = 1'b0;
                        ramp_timer_next = '0;
                        ramp_from_next  = target_reg;
                        ramp_to_next    = target_reg;
                    end
                    KIND_RAMP: begin
                        br_go     = 1'b1;
                        br_target = target_reg;
                        br_span   = rtime_reg;
                    end
                    KIND_TOGGLE: begin
                        br_go     = 1'b1;
                        br_target = level_reg[LEVEL_W-1] ? '0 : toggle_level_reg;
                        br_span   = rtime_reg;
                    end
                    default: ;
                endcase
                if (br_go) begin
                    ramp_from_next  = level_reg;
                    ramp_to_next    = br_target;
                    ramp_timer_next = '0;
                    ramp_span_next  = br_span;
                    if (br_span == '0) begin
                        level_next   = br_target;
                        ramp_on_next = 1'b0;
                    end else begin
                        ramp_on_next = 1'b1;
                    end
                end
            end
            ST_RAMP: begin
                if (ramp_on_reg) begin
                    ramp_timer_next = ramp_sum;
                    if (ramp_reach) begin
                        level_next   = ramp_to_reg;
                        ramp_on_next = 1'b0;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) t_next = div_quotient;
            end
            ST_MUL_TT: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(t_reg);
            end
            ST_MUL_CUBE: begin
                // t^2 * (3 - 2t), with t^2 in Q32 and t and 3 - 2t in Q16
                mul_a = mul_p[MUL_A_W-1:0];
                mul_b = MUL_B_W'(18'h30000) - {1'b0, t_reg, 1'b0};
            end
            ST_SMOOTH: begin
                s_next = smooth_sum[MUL_A_W+LEVEL_W:MUL_A_W];
            end
            ST_MUL_DIFF: begin
                mul_a = MUL_A_W'(ramp_diff);
                mul_b = MUL_B_W'(s_reg);
            end
            ST_STEP: begin
                level_next = ramp_up ? ramp_from_reg + step_d : ramp_from_reg - step_d;
            end
            ST_FOG: begin
                mul_a        = MUL_A_W'(fog_base(fog_cnt_reg));
                mul_b        = MUL_B_W'(level_inv);
                fog_cnt_next = fog_cnt_reg + FOG_IDX_W'(1);
                if (fog_cnt_reg != '0) begin
                    color_next[fog_prev] = round_sum[LEVEL_W+COLOR_W-1:LEVEL_W];
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, color_reg[5], color_reg[4], color_reg[3],
                                     color_reg[2], color_reg[1], color_reg[0],
                                     ramp_on_reg, cycle_on_reg, phase_reg, level_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cycle_on_reg    <= 1'b0;
            phase_reg       <= PH_DAY_HOLD;
            cycle_timer_reg <= '0;
            ramp_on_reg     <= 1'b0;
            ramp_timer_reg  <= '0;
            ramp_span_reg   <= '0;
            ramp_from_reg   <= '0;
            ramp_to_reg     <= '0;
            level_reg       <= '0;
            fog_cnt_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cycle_on_reg    <= cycle_on_next;
            phase_reg       <= phase_next;
            cycle_timer_reg <= cycle_timer_next;
            ramp_on_reg     <= ramp_on_next;
            ramp_timer_reg  <= ramp_timer_next;
            ramp_span_reg   <= ramp_span_next;
            ramp_from_reg   <= ramp_from_next;
            ramp_to_reg     <= ramp_to_next;
            level_reg       <= level_next;
            fog_cnt_reg     <= fog_cnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg    <= hres_kind_t'(s_tuser);
            elapsed_reg <= s_tdata[ELAPSED_W-1:0];
            target_reg  <= s_tdata[ELAPSED_W+LEVEL_W-1:ELAPSED_W];
            rtime_reg   <= s_tdata[ELAPSED_W+LEVEL_W+TIME_W-1:ELAPSED_W+LEVEL_W];
        end
        t_reg       <= t_next;
        s_reg       <= s_next;
        color_reg   <= color_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_ramp_span_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ramp_on_reg |-> ramp_span_reg != '0)
        else $error("ramp running with zero span");

    a_cycle_off_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        !cycle_on_reg |-> cycle_timer_reg == '0)
        else $error("cycle timer nonzero while cycle stopped");

    a_level_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        ramp_on_reg |->
            ((ramp_to_reg >= ramp_from_reg) && (level_reg >= ramp_from_reg)
                && (level_reg <= ramp_to_reg))
            || ((ramp_to_reg < ramp_from_reg) && (level_reg <= ramp_from_reg)
                && (level_reg >= ramp_to_reg)))
        else $error("level outside ramp endpoints");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide wait");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb
    import hres_pkg::*;
();

    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    localparam int QUIET_LIMIT    = 4000;
    localparam int HOLDOFF_AT     = 460;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 60;
    localparam int MAX_REPORTS    = 40;

    // day fog colors, horizon rgb then top rgb, index 0 in the low byte
    localparam logic [5:0][7:0] DAY_FOG = {8'd255, 8'd191, 8'd140, 8'd242, 8'd204, 8'd153};

    typedef bit [63:0] u64_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ELAPSED_W-1:0] elapsed;
        logic [LEVEL_W-1:0]   target;
        logic [TIME_W-1:0]    span;
    } cmd_t;

    // laid out as m_tdata[67:0]
    typedef struct packed {
        logic [5:0][7:0]    fog;
        logic               rrun;
        logic               crun;
        logic [1:0]         phase;
        logic [LEVEL_W-1:0] level;
    } look_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    logic calm = 1'b0;

    cmd_t  cmd_q[$];
    look_t look_q[$];
    int    n_queued  = 0;
    int    n_got     = 0;
    int    mism_cnt  = 0;
    int    rx_seen   = 0;
    int    hold_left = 0;
    int    quiet     = 0;

    // envelope state and register copies
    logic [15:0] cfg_day, cfg_night, cfg_ramp, cfg_nlevel, cfg_tlevel;
    bit          en_cycle, en_ramp;
    hres_phase_t en_phase;
    u64_t        en_ctimer, en_rtimer, en_span, en_from, en_to, en_level;

    hold_ramp_envelope_sequencer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic u64_t timer_sum(input u64_t a, input u64_t b);
        u64_t s;
        s = a + b;
        return (s > u64_t'(TIMER_MAX)) ? u64_t'(TIMER_MAX) : s;
    endfunction

    function automatic void launch_ramp(input u64_t target, input u64_t span);
        en_from   = en_level;
        en_to     = target;
        en_rtimer = 0;
        en_span   = span;
        if (span == 0) begin
            en_level = en_to;
            en_ramp  = 1'b0;
        end else begin
            en_ramp = 1'b1;
        end
    endfunction

    function automatic void sequencer_tick(input u64_t dt);
        if (!en_cycle) return;
        en_ctimer = timer_sum(en_ctimer, dt);
        case (en_phase)
            PH_DAY_HOLD: begin
                if (en_ctimer >= cfg_day) begin
                    en_ctimer = 0;
                    en_phase  = PH_TO_NIGHT;
                    launch_ramp(cfg_nlevel, cfg_ramp);
                end
            end
            PH_TO_NIGHT: begin
                if (en_ctimer >= cfg_ramp) begin
                    en_ctimer = 0;
                    en_phase  = PH_NIGHT_HOLD;
                end
            end
            PH_NIGHT_HOLD: begin
                if (en_ctimer >= cfg_night) begin
                    en_ctimer = 0;
                    en_phase  = PH_TO_DAY;
                    launch_ramp(0, cfg_ramp);
                end
            end
            default: begin
                if (en_ctimer >= cfg_ramp) begin
                    en_ctimer = 0;
                    en_phase  = PH_DAY_HOLD;
                end
            end
        endcase
    endfunction

    function automatic void ease_tick(input u64_t dt);
        u64_t t, s, d;
        if (!en_ramp) return;
        en_rtimer = timer_sum(en_rtimer, dt);
        if (en_span == 0 || en_rtimer >= en_span) begin
            en_level = en_to;
            en_ramp  = 1'b0;
            return;
        end
        t = (en_rtimer << 16) / en_span;
        s = (t * t * (64'd196608 - 2 * t) + 64'h8000_0000) >> 32;
        if (en_to >= en_from) begin
            d = ((en_to - en_from) * s + 64'd32768) >> 16;
            en_level = (en_from + d) & 64'hFFFF;
        end else begin
            d = ((en_from - en_to) * s + 64'd32768) >> 16;
            en_level = (en_from - d) & 64'hFFFF;
        end
    endfunction

    function automatic look_t step_envelope(input cmd_t c);
        look_t r;
        u64_t  inv;
        case (c.kind)
            KIND_TICK: begin
                sequencer_tick(c.elapsed);
                ease_tick(c.elapsed);
            end
            KIND_START: begin
                en_cycle  = 1'b1;
                en_phase  = PH_DAY_HOLD;
                en_ctimer = 0;
            end
            KIND_STOP: begin
                en_cycle  = 1'b0;
                en_ctimer = 0;
            end
            KIND_SET: begin
                en_level  = c.target;
                en_ramp   = 1'b0;
                en_rtimer = 0;
                en_from   = en_level;
                en_to     = en_level;
            end
            KIND_RAMP:   launch_ramp(c.target, c.span);
            KIND_TOGGLE: launch_ramp((en_level < 64'd32768) ? u64_t'(cfg_tlevel) : 64'd0, c.span);
            default: ;
        endcase
        inv     = 64'd65536 - en_level;
        r.level = en_level[15:0];
        r.phase = en_phase;
        r.crun  = en_cycle;
        r.rrun  = en_ramp;
        for (int i = 0; i < 6; i++) begin
            r.fog[i] = 8'((u64_t'(DAY_FOG[i]) * inv + 64'd32768) >> 16);
        end
        return r;
    endfunction

    function automatic void match_field(input string what, input int unsigned want,
                                        input int unsigned seen);
        if (want != seen) begin
            mism_cnt++;
            if (mism_cnt <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, what, want, seen);
        end
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                look_q.push_back(step_envelope(cmd_q.pop_front()));
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, cmd_q[0].span, cmd_q[0].target, cmd_q[0].elapsed};
                    s_tuser  <= cmd_q[0].kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin : rx
        look_t seen, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = look_t'(m_tdata[67:0]);
                n_got <= n_got + 1;
                rx_seen++;
                if (look_q.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected transfer, expected none actual %h",
                                 $time, m_tdata);
                end else begin
                    want = look_q.pop_front();
                    match_field("level", want.level, seen.level);
                    match_field("cycle_phase", want.phase, seen.phase);
                    match_field("cycle_running", want.crun, seen.crun);
                    match_field("ramp_running", want.rrun, seen.rrun);
                    for (int i = 0; i < 6; i++)
                        match_field($sformatf("fog color %0d", i), want.fog[i], seen.fog[i]);
                end
                if (rx_seen == HOLDOFF_AT) hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic cfg_write(input hres_reg_t idx, input logic [15:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DAY_HOLD:     cfg_day    = val;
            REG_NIGHT_HOLD:   cfg_night  = val;
            REG_RAMP_LEN:     cfg_ramp   = val;
            REG_NIGHT_LEVEL:  cfg_nlevel = val;
            REG_TOGGLE_LEVEL: cfg_tlevel = val;
            default: ;
        endcase
    endtask

    task automatic cfg_all(input logic [15:0] day, input logic [15:0] night,
                           input logic [15:0] ramp, input logic [15:0] nlevel,
                           input logic [15:0] tlevel);
        cfg_write(REG_DAY_HOLD, day);
        cfg_write(REG_NIGHT_HOLD, night);
        cfg_write(REG_RAMP_LEN, ramp);
        cfg_write(REG_NIGHT_LEVEL, nlevel);
        cfg_write(REG_TOGGLE_LEVEL, tlevel);
        @(negedge aclk);
    endtask

    task automatic add(input logic [KIND_W-1:0] k, input int el, input int tg, input int sp);
        cmd_t c;
        c.kind    = k;
        c.elapsed = el[ELAPSED_W-1:0];
        c.target  = tg[LEVEL_W-1:0];
        c.span    = sp[TIME_W-1:0];
        cmd_q.push_back(c);
        n_queued++;
    endtask

    task automatic add_random(input int count);
        int r, el, tg, sp;
        logic [KIND_W-1:0] k;
        add(KIND_START, $urandom_range(1023), $urandom_range(65535), $urandom_range(65535));
        repeat (count - 1) begin
            r = $urandom_range(99);
            if (r < 52)      k = KIND_TICK;
            else if (r < 60) k = KIND_START;
            else if (r < 64) k = KIND_STOP;
            else if (r < 72) k = KIND_SET;
            else if (r < 85) k = KIND_RAMP;
            else if (r < 94) k = KIND_TOGGLE;
            else             k = $urandom_range(1) ? KIND_SPARE7 : KIND_SPARE6;
            case ($urandom_range(3))
                0, 1: el = $urandom_range(1023);
                2:    el = $urandom_range(40);
                default: el = $urandom_range(1) ? 1023 : 0;
            endcase
            case ($urandom_range(4))
                0:       tg = $urandom_range(1) ? 65535 : 0;
                default: tg = $urandom_range(65535);
            endcase
            case ($urandom_range(3))
                0: sp = 0;
                1: sp = $urandom_range(4000, 1);
                2: sp = $urandom_range(65535);
                default: sp = $urandom_range(300, 1);
            endcase
            add(k, el, tg, sp);
        end
    endtask

    task automatic wait_drained;
        while (n_got < n_queued) @(posedge aclk);
    endtask

    initial begin
        cfg_day    = 16'd1000;
        cfg_night  = 16'd1000;
        cfg_ramp   = 16'd200;
        cfg_nlevel = 16'd65535;
        cfg_tlevel = 16'd52429;
        en_cycle   = 1'b0;
        en_ramp    = 1'b0;
        en_phase   = PH_DAY_HOLD;
        en_ctimer  = 0;
        en_rtimer  = 0;
        en_span    = 0;
        en_from    = 0;
        en_to      = 0;
        en_level   = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add(KIND_TICK,   0,    65535, 65535);
        add(KIND_SET,    1023, 65535, 0);
        add(KIND_TOGGLE, 0,    0,     0);      // level high, jumps to day
        add(KIND_TOGGLE, 0,    0,     0);      // level low, jumps to toggle night level
        add(KIND_SET,    0,    0,     65535);
        add(KIND_RAMP,   0,    65535, 1);
        add(KIND_TICK,   1,    0,     0);
        add(KIND_RAMP,   0,    0,     65535);
        add(KIND_TICK,   1023, 0,     0);
        add(KIND_TICK,   1023, 0,     0);
        add(KIND_TICK,   1023, 0,     0);
        add(KIND_RAMP,   0,    40000, 3000);
        add(KIND_TICK,   777,  0,     0);
        add(KIND_TICK,   1023, 0,     0);
        add(KIND_TICK,   1023, 0,     0);
        add(KIND_TICK,   1023, 0,     0);
        add(KIND_SPARE6, 1023, 65535, 65535);
        add(KIND_SPARE7, 1023, 65535, 65535);
        add(KIND_START,  0,    0,     0);
        add(KIND_TICK,   1023, 0,     0);
        add(KIND_TICK,   100,  0,     0);
        add(KIND_TICK,   200,  0,     0);
        add(KIND_TOGGLE, 0,    0,     500);
        add(KIND_STOP,   0,    0,     0);      // ramp keeps going
        add(KIND_TICK,   250,  0,     0);
        add_random(150);
        wait_drained();

        // zero hold and ramp times
        cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        add_random(80);
        wait_drained();

        cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_random(80);
        wait_drained();

        cfg_all(16'($urandom_range(3000)), 16'($urandom_range(3000)),
                16'($urandom_range(1500)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)));
        calm <= 1'b1;
        add_random(100);
        wait_drained();
        calm <= 1'b0;

        cfg_all(16'($urandom_range(8000)), 16'($urandom_range(8000)),
                16'($urandom_range(4000)), 16'($urandom_range(65535)),
                16'($urandom_range(65535)));
        add_random(120);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mism_cnt == 0 && look_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
